/* rtl/comment_strip_line_split_macros.svh */
// Assertion macros for the comment stripper checker.
// Assumes clk and rst are visible in the scope that uses them.
`ifndef COMMENT_STRIP_LINE_SPLIT_MACROS_SVH
`define COMMENT_STRIP_LINE_SPLIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CSLS_ASSERT_IMP(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("csls check failed");

// Next-cycle implication, disabled during reset.
`define CSLS_ASSERT_NXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("csls check failed");

// Next-cycle implication that also holds across reset.
`define CSLS_ASSERT_NXT_NR(label, cond, prop) \
  label: assert property (@(posedge clk) (cond) |=> (prop)) \
    else $error("csls check failed");

`endif

/* rtl/csls_pkg.sv */
// Shared types and character constants for the comment stripper.
// No dependencies.
package csls_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_STRING = 3'd1,
    MODE_CHAR   = 3'd2,
    MODE_SLASH  = 3'd3,
    MODE_LINE   = 3'd4,
    MODE_BLOCK  = 3'd5
  } scan_mode_t;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SP    = 8'h20;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } scan_out_t;

endpackage

/* rtl/csls_scan.sv */
// Six-mode scanner: state registers and per-byte result generation.
// Depends on csls_pkg.
module csls_scan (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          in_byte,
  output csls_pkg::scan_out_t scan
);
  import csls_pkg::*;

  typedef struct packed {
    scan_mode_t mode;
    logic       emit;
    logic [7:0] data;
  } norm_t;

  scan_mode_t mode, mode_next;
  logic       str_esc, str_esc_next;
  logic       chr_esc, chr_esc_next;
  logic       line_esc, line_esc_next;
  logic       star, star_next;
  logic       c0_v, c1_v, k0, k1;
  logic [7:0] c0, c1;

  function automatic logic [7:0] map_plain(input logic [7:0] b);
    if (b == CH_NL) return CH_SP;
    if (b == CH_SEMI) return CH_NL;
    return b;
  endfunction

  function automatic norm_t normal_step(input logic [7:0] b);
    norm_t r;
    r.mode = MODE_NORMAL;
    r.emit = 1'b1;
    r.data = map_plain(b);
    if (b == CH_DQ) begin
      r.mode = MODE_STRING;
    end else if (b == CH_SQ) begin
      r.mode = MODE_CHAR;
    end else if (b == CH_SLASH) begin
      r.mode = MODE_SLASH;
      r.emit = 1'b0;
    end
    return r;
  endfunction

  always_comb begin
    norm_t n;
    n             = normal_step(in_byte);
    mode_next     = mode;
    str_esc_next  = str_esc;
    chr_esc_next  = chr_esc;
    line_esc_next = line_esc;
    star_next     = star;
    c0_v          = 1'b0;
    c0            = in_byte;
    c1_v          = 1'b0;
    c1            = in_byte;
    unique case (mode)
      MODE_STRING: begin
        c0_v = 1'b1;
        if (in_byte == CH_DQ && !str_esc) mode_next = MODE_NORMAL;
        str_esc_next = (in_byte == CH_BSL) && !str_esc;
      end
      MODE_CHAR: begin
        c0_v = 1'b1;
        if (in_byte == CH_SQ && !chr_esc) mode_next = MODE_NORMAL;
        chr_esc_next = (in_byte == CH_BSL) && !chr_esc;
      end
      MODE_SLASH: begin
        if (in_byte == CH_SLASH) begin
          mode_next = MODE_LINE;
        end else if (in_byte == CH_STAR) begin
          mode_next = MODE_BLOCK;
        end else begin
          // lone slash: emit it, then treat this byte as normal text
          c0_v      = 1'b1;
          c0        = CH_SLASH;
          c1_v      = n.emit;
          c1        = n.data;
          mode_next = n.mode;
        end
      end
      MODE_LINE: begin
        if (in_byte == CH_NL && !line_esc) begin
          c0_v      = 1'b1;
          c0        = map_plain(in_byte);
          mode_next = MODE_NORMAL;
        end
        line_esc_next = (in_byte == CH_BSL) && !line_esc;
      end
      MODE_BLOCK: begin
        if (in_byte == CH_SLASH && star) begin
          c0_v      = 1'b1;
          c0        = CH_SP;
          mode_next = MODE_NORMAL;
        end
        star_next = (in_byte == CH_STAR);
      end
      default: begin
        c0_v      = n.emit;
        c0        = n.data;
        mode_next = n.mode;
      end
    endcase
  end

  // space and tab are never emitted
  assign k0 = c0_v && (c0 != CH_SP) && (c0 != CH_TAB);
  assign k1 = c1_v && (c1 != CH_SP) && (c1 != CH_TAB);

  always_comb begin
    scan.count     = {1'b0, k0} + {1'b0, k1};
    scan.res0.data = k0 ? c0 : c1;
    scan.res0.last = !(k0 && k1);
    scan.res1.data = c1;
    scan.res1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_NORMAL;
      str_esc  <= 1'b0;
      chr_esc  <= 1'b0;
      line_esc <= 1'b0;
      star     <= 1'b0;
    end else if (accept) begin
      mode     <= mode_next;
      str_esc  <= str_esc_next;
      chr_esc  <= chr_esc_next;
      line_esc <= line_esc_next;
      star     <= star_next;
    end
  end

endmodule

/* rtl/csls_outq.sv */
// Result queue: takes up to two results per request, releases one per cycle unless out_stall is high.
// Depends on csls_pkg.
module csls_outq (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  csls_pkg::scan_out_t scan,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                last_of_run
);
  import csls_pkg::*;

  result_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wp, rp;
  logic [QCNT_W-1:0]   count, count_next;
  logic [1:0]          n;
  logic                pop;

  assign n         = push ? scan.count : 2'd0;
  assign pop       = out_valid && !out_stall;
  assign out_valid = (count != '0);
  // room for two more results is required before taking a request
  assign full      = (count > QCNT_W'(QUEUE_DEPTH - 2));
  assign out_byte    = mem[rp].data;
  assign last_of_run = mem[rp].last;

  assign count_next = count + QCNT_W'(n) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (n != 2'd0) mem[wp] <= scan.res0;
    if (n == 2'd2) mem[wp + QPTR_W'(1)] <= scan.res1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + QPTR_W'(n);
      rp    <= rp + QPTR_W'(pop);
      count <= count_next;
    end
  end

endmodule

/* rtl/comment_strip_line_split.sv */
// Top level of the comment stripper and statement splitter.
// Depends on csls_pkg, csls_scan and csls_outq.
//
// Takes one text byte per request and emits 0, 1 or 2 cleaned bytes, the
// last of them flagged by last_of_run. The scanner updates its mode in the
// cycle a byte is taken, so one byte can be taken every clock unless
// in_stall is high. Results leave a four-entry queue one per clock unless
// out_stall is high; in_stall rises while it holds three or more results.
// With out_stall low, one byte per cycle is sustained while bytes average
// at most one result; a lone slash and a printable byte give two results.
module comment_strip_line_split (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       last_of_run
);
  import csls_pkg::*;

  scan_out_t scan;
  logic      accept;

  assign accept = in_valid && !in_stall;

  csls_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_byte),
    .scan    (scan)
  );

  csls_outq u_outq (
    .clk         (clk),
    .rst         (rst),
    .push        (accept),
    .scan        (scan),
    .full        (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule

/* rtl/csls_checker.sv */
// Port-level checks for comment_strip_line_split, bound to the top level.
// Uses comment_strip_line_split_macros.svh.
`include "comment_strip_line_split_macros.svh"

module csls_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       last_of_run
);

  `CSLS_ASSERT_NXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_byte))
  `CSLS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
  `CSLS_ASSERT_NXT_NR(a_reset_empty, rst, !out_valid && !in_stall)
  `CSLS_ASSERT_IMP(a_no_blank, out_valid, out_byte != 8'h20 && out_byte != 8'h09)
  `CSLS_ASSERT_IMP(a_stall_backlog, in_stall, out_valid)

endmodule

bind comment_strip_line_split csls_checker u_csls_checker (.*);
